// ===== hdl/rmedf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmedf_pkg
// Shared types, sizes and codes of the rate-monotonic / EDF task scheduler.
// ----------------------------------------------------------------------------
package rmedf_pkg;

  // Table geometry.
  localparam int MAX_TASKS = 16;
  localparam int TIME_BITS = 16;

  localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int DL_W   = TIME_BITS + 1;

  // Fixed field widths of the ports.
  localparam int KIND_W     = 1;
  localparam int SLOT_IN_W  = 4;
  localparam int TIME_IN_W  = 16;
  localparam int SLOT_OUT_W = 4;
  localparam int REM_OUT_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
  localparam logic [KIND_W-1:0] KIND_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT  = 2'd1;

  // Selection policies.
  localparam logic POLICY_RM  = 1'b0;
  localparam logic POLICY_EDF = 1'b1;

  // One row of the task table.
  typedef struct packed {
    logic [TIME_BITS-1:0]   period;
    logic [TIME_BITS-1:0]   remaining;
    logic signed [DL_W-1:0] deadline;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_WB
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic load_wr;
    logic scan_rd;
    logic wb;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_end;
  } dp_status_t;

endpackage : rmedf_pkg
`default_nettype wire

// ===== hdl/rm_edf_task_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rm_edf_task_scheduler
// Task table scheduled one tick at a time by rate-monotonic or EDF priority.
// ----------------------------------------------------------------------------
// An item is taken when start is high while busy is low. A load passes through
// the load state alone. A tick runs a serial scan over task_count slots, capped
// at sixteen, that reads one table row per cycle from the single read port of
// the task table, followed by a write-back state. Each item produces exactly
// one result, shown for a single cycle with done_o high; it cannot be held off,
// so the receiver must take it in that cycle. Busy drops in the same cycle the
// result appears, so the next item may be taken right away. Configuration
// writes are always ready and are meant only while the block is idle.
module rm_edf_task_scheduler (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [rmedf_pkg::KIND_W-1:0]      kind_i,
  input  wire logic [rmedf_pkg::SLOT_IN_W-1:0]   slot_i,
  input  wire logic [rmedf_pkg::TIME_IN_W-1:0]   task_period_i,
  input  wire logic [rmedf_pkg::TIME_IN_W-1:0]   exec_time_i,
  output logic                                   done_o,
  output logic                                   ran_o,
  output logic [rmedf_pkg::SLOT_OUT_W-1:0]       chosen_slot_o,
  output logic [rmedf_pkg::REM_OUT_W-1:0]        remaining_left_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [rmedf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [rmedf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  rmedf_pkg::ctrl_cmd_t  cmd;
  rmedf_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  rmedf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .kind_i   (kind_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  rmedf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_valid_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .slot_i           (slot_i),
    .task_period_i    (task_period_i),
    .exec_time_i      (exec_time_i),
    .done_o           (done_o),
    .ran_o            (ran_o),
    .chosen_slot_o    (chosen_slot_o),
    .remaining_left_o (remaining_left_o)
  );

endmodule : rm_edf_task_scheduler
`default_nettype wire

// ===== hdl/rmedf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmedf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rmedf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : rmedf_ram
`default_nettype wire

// ===== hdl/rmedf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmedf_ctrl
// Sequencer of the scheduler: load, serial scan and write-back.
// ----------------------------------------------------------------------------
module rmedf_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  input  wire logic [rmedf_pkg::KIND_W-1:0]  kind_i,
  input  wire rmedf_pkg::dp_status_t         status_i,
  output rmedf_pkg::ctrl_cmd_t               cmd_o,
  output logic                               busy
);

  rmedf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmedf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmedf_pkg::ST_IDLE: begin
        if (start) begin
          state_d = (kind_i == rmedf_pkg::KIND_TICK) ? rmedf_pkg::ST_SCAN
                                                     : rmedf_pkg::ST_LOAD;
        end
      end
      rmedf_pkg::ST_LOAD: begin
        state_d = rmedf_pkg::ST_IDLE;
      end
      rmedf_pkg::ST_SCAN: begin
        if (status_i.scan_end) begin
          state_d = rmedf_pkg::ST_WB;
        end
      end
      rmedf_pkg::ST_WB: begin
        state_d = rmedf_pkg::ST_IDLE;
      end
      default: begin
        state_d = rmedf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      rmedf_pkg::ST_IDLE: begin
        busy          = 1'b0;
        cmd_o.capture = start;
      end
      rmedf_pkg::ST_LOAD: begin
        cmd_o.load_wr = 1'b1;
      end
      rmedf_pkg::ST_SCAN: begin
        cmd_o.scan_rd = !status_i.scan_end;
      end
      rmedf_pkg::ST_WB: begin
        cmd_o.wb = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule : rmedf_ctrl
`default_nettype wire

// ===== hdl/rmedf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmedf_dp
// Datapath: configuration registers, task table, scan comparator and results.
// ----------------------------------------------------------------------------
module rmedf_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire rmedf_pkg::ctrl_cmd_t              cmd_i,
  output rmedf_pkg::dp_status_t                  status_o,
  input  wire logic                              cfg_valid_i,
  input  wire logic [rmedf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [rmedf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic [rmedf_pkg::SLOT_IN_W-1:0]   slot_i,
  input  wire logic [rmedf_pkg::TIME_IN_W-1:0]   task_period_i,
  input  wire logic [rmedf_pkg::TIME_IN_W-1:0]   exec_time_i,
  output logic                                   done_o,
  output logic                                   ran_o,
  output logic [rmedf_pkg::SLOT_OUT_W-1:0]       chosen_slot_o,
  output logic [rmedf_pkg::REM_OUT_W-1:0]        remaining_left_o
);

  localparam int SLOT_W = rmedf_pkg::SLOT_W;
  localparam int CNT_W  = rmedf_pkg::CNT_W;
  localparam int DL_W   = rmedf_pkg::DL_W;
  localparam int TB     = rmedf_pkg::TIME_BITS;

  // Configuration.
  logic                         policy_q;
  logic [rmedf_pkg::CFG_DATA_W-1:0] task_count_q;
  logic [CNT_W-1:0]             eff_count;

  // Captured load item.
  logic [rmedf_pkg::SLOT_IN_W-1:0] slot_q;
  logic [TB-1:0]                period_q;
  logic [TB-1:0]                exec_q;
  logic                         slot_ok;

  // Scan state.
  logic [CNT_W-1:0]             idx_q;
  logic                         rd_vld_q;
  logic [SLOT_W-1:0]            rd_addr_q;
  logic                         rd_vbit_q;
  logic [rmedf_pkg::MAX_TASKS-1:0] valid_q;
  logic                         found_q;
  logic [SLOT_W-1:0]            best_idx_q;
  rmedf_pkg::entry_t            best_q;

  // Table port.
  logic                         ram_we;
  logic [SLOT_W-1:0]            ram_waddr;
  rmedf_pkg::entry_t            ram_wdata;
  rmedf_pkg::entry_t            ram_rdata;
  rmedf_pkg::entry_t            load_entry;
  rmedf_pkg::entry_t            wb_entry;

  logic signed [DL_W-1:0]       cand_key;
  logic signed [DL_W-1:0]       best_key;
  logic                         take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q     <= rmedf_pkg::POLICY_RM;
      task_count_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rmedf_pkg::CFG_POLICY_MODE: policy_q     <= cfg_data_i[0];
        rmedf_pkg::CFG_TASK_COUNT:  task_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(task_count_q) > rmedf_pkg::MAX_TASKS) begin
      eff_count = CNT_W'(rmedf_pkg::MAX_TASKS);
    end else begin
      eff_count = CNT_W'(task_count_q);
    end
  end

  assign status_o.scan_end = (idx_q == eff_count);
  assign slot_ok = (int'(slot_q) < rmedf_pkg::MAX_TASKS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      slot_q   <= slot_i;
      period_q <= TB'(task_period_i);
      exec_q   <= TB'(exec_time_i);
    end
  end

  // Scan counter, read pipeline and valid bits of the table rows.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      valid_q  <= '0;
      found_q  <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.capture) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          idx_q <= idx_q + 1'b1;
        end
        if (take) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.load_wr && slot_ok) begin
        valid_q[SLOT_W'(slot_q)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      rd_addr_q <= idx_q[SLOT_W-1:0];
      rd_vbit_q <= valid_q[idx_q[SLOT_W-1:0]];
    end
    if (take) begin
      best_idx_q <= rd_addr_q;
      best_q     <= ram_rdata;
    end
  end

  // Rate-monotonic ranks by period, which is never negative as a key.
  always_comb begin
    if (policy_q == rmedf_pkg::POLICY_EDF) begin
      cand_key = ram_rdata.deadline;
      best_key = best_q.deadline;
    end else begin
      cand_key = signed'({1'b0, ram_rdata.period});
      best_key = signed'({1'b0, best_q.period});
    end
  end

  // A row that was never loaded is skipped by its valid bit, as is a row with no
  // remaining time. Strict compare keeps the lowest slot on ties.
  assign take = rd_vld_q && rd_vbit_q && (ram_rdata.remaining != '0)
             && (!found_q || (cand_key < best_key));

  always_comb begin
    load_entry.period    = period_q;
    load_entry.remaining = exec_q;
    load_entry.deadline  = signed'({1'b0, period_q});

    wb_entry           = best_q;
    wb_entry.remaining = best_q.remaining - 1'b1;
    if (policy_q == rmedf_pkg::POLICY_EDF) begin
      wb_entry.deadline = best_q.deadline - DL_W'(1);
    end
  end

  always_comb begin
    if (cmd_i.wb) begin
      ram_we    = found_q;
      ram_waddr = best_idx_q;
      ram_wdata = wb_entry;
    end else begin
      ram_we    = cmd_i.load_wr && slot_ok;
      ram_waddr = SLOT_W'(slot_q);
      ram_wdata = load_entry;
    end
  end

  rmedf_ram #(
    .WIDTH (rmedf_pkg::ENTRY_W),
    .DEPTH (rmedf_pkg::MAX_TASKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (idx_q[SLOT_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o           <= 1'b0;
      ran_o            <= 1'b0;
      chosen_slot_o    <= '0;
      remaining_left_o <= '0;
    end else begin
      done_o <= cmd_i.load_wr || cmd_i.wb;
      if (cmd_i.wb && found_q) begin
        ran_o            <= 1'b1;
        chosen_slot_o    <= rmedf_pkg::SLOT_OUT_W'(best_idx_q);
        remaining_left_o <= rmedf_pkg::REM_OUT_W'(wb_entry.remaining);
      end else if (cmd_i.load_wr || cmd_i.wb) begin
        ran_o            <= 1'b0;
        chosen_slot_o    <= '0;
        remaining_left_o <= '0;
      end
    end
  end

endmodule : rmedf_dp
`default_nettype wire

// ===== hdl/rmedf_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmedf_chk
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rmedf_chk (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              done_o,
  input wire logic                              ran_o,
  input wire logic [rmedf_pkg::SLOT_OUT_W-1:0]  chosen_slot_o,
  input wire logic [rmedf_pkg::REM_OUT_W-1:0]   remaining_left_o
);

  // Busy is high in the cycle after an accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted item");

  // The block only goes idle when it hands out the item's result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy fell without a result");

  // Results never come back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in consecutive cycles");

  // A result that ran nothing carries all-zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ran_o) |-> (chosen_slot_o == '0 && remaining_left_o == '0))
    else $error("idle or load result with nonzero fields");

endmodule : rmedf_chk

bind rm_edf_task_scheduler rmedf_chk u_rmedf_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_o           (done_o),
  .ran_o            (ran_o),
  .chosen_slot_o    (chosen_slot_o),
  .remaining_left_o (remaining_left_o)
);
`default_nettype wire
